// ----- src/nand_page_read_sequencer_defines.svh -----
// Assertion macros shared by the read sequencer modules.
`ifndef NAND_PAGE_READ_SEQUENCER_DEFINES_SVH
`define NAND_PAGE_READ_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define NPRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define NPRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nprs_pkg.sv -----
// Types, codes and constants of the NAND page read sequencer.
package nprs_pkg;

    localparam int PAGE_BYTES_DEF = 2048;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_READY = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_CONFIRM = 8'h30;

    typedef enum logic [2:0] {
        OP_SELECT  = 3'd0,
        OP_CMD     = 3'd1,
        OP_ADDR    = 3'd2,
        OP_DATA    = 3'd3,
        OP_RELEASE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // What the back end has to play out for one transaction.
    typedef enum logic [2:0] {
        JOB_START_SEQ = 3'd0,
        JOB_START_REL = 3'd1,
        JOB_DATA      = 3'd2,
        JOB_DATA_REL  = 3'd3,
        JOB_DATA_SEQ  = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic [31:0] offset;
        logic [31:0] addr;
    } job_t;

    // Step numbers within a job: step 0 is select or data.
    localparam logic [2:0] STEP_FIRST    = 3'd0;
    localparam logic [2:0] STEP_REL_LAST = 3'd1;
    localparam logic [2:0] STEP_SEQ_LAST = 3'd7;
    localparam logic [2:0] STEP_CMD_READ = 3'd1;
    localparam logic [2:0] STEP_COL_LO   = 3'd2;
    localparam logic [2:0] STEP_COL_HI   = 3'd3;
    localparam logic [2:0] STEP_PAGE_0   = 3'd4;
    localparam logic [2:0] STEP_PAGE_1   = 3'd5;
    localparam logic [2:0] STEP_PAGE_2   = 3'd6;

endpackage

// ----- src/nprs_queue.sv -----
// Small job FIFO between the front end and the back end.
module nprs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  nprs_pkg::job_t  wr_data,
    input  logic            rd_en,
    output nprs_pkg::job_t  rd_data,
    output logic            full,
    output logic            empty
);
    import nprs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/nprs_front.sv -----
// Front end: takes input transactions, tracks the read phase and queues jobs.
`include "nand_page_read_sequencer_defines.svh"

module nprs_front #(
    parameter int PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      action,
    input  logic [31:0]     start_address,
    input  logic [31:0]     read_length,
    input  logic            ready_flag,
    input  logic [7:0]      flash_byte,
    input  logic            q_full,
    output logic            q_push,
    output nprs_pkg::job_t  q_job
);
    import nprs_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    phase_t      phase_reg, phase_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] addr_inc, done_inc;
    logic        accept, last_byte, boundary;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign addr_inc  = addr_reg + 32'd1;
    assign done_inc  = done_reg + 32'd1;
    assign last_byte = (done_inc == total_reg);
    assign boundary  = (addr_inc[PAGE_SHIFT-1:0] == '0);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (action == ACT_START && read_length != '0) begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (action == ACT_READY && ready_flag) begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (action == ACT_DATA) begin
                        if (last_byte) begin
                            phase_next = PH_IDLE;
                        end else if (boundary) begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // job and counter updates
    always_comb begin
        q_push        = 1'b0;
        q_job.kind    = JOB_DATA;
        q_job.data    = flash_byte;
        q_job.offset  = done_reg;
        q_job.addr    = addr_reg;
        addr_next     = addr_reg;
        done_next     = done_reg;
        total_next    = total_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (action == ACT_START) begin
                        q_push     = 1'b1;
                        q_job.kind = (read_length == '0) ? JOB_START_REL : JOB_START_SEQ;
                        q_job.addr = start_address;
                        addr_next  = start_address;
                        total_next = read_length;
                        done_next  = '0;
                    end
                end
                PH_DATA: begin
                    if (action == ACT_DATA) begin
                        q_push     = 1'b1;
                        q_job.addr = addr_inc;
                        addr_next  = addr_inc;
                        done_next  = done_inc;
                        if (last_byte) begin
                            q_job.kind = JOB_DATA_REL;
                        end else if (boundary) begin
                            q_job.kind = JOB_DATA_SEQ;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            done_reg  <= '0;
            total_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
            total_reg <= total_next;
        end
    end

    `NPRS_ASSERT_NEXT(a_seq_waits, q_push && (q_job.kind == JOB_START_SEQ || q_job.kind == JOB_DATA_SEQ), phase_reg == PH_WAIT, "sequence job without wait phase")
    `NPRS_ASSERT_NOW(a_done_below_total, phase_reg == PH_DATA, done_reg < total_reg, "byte count reached length in data phase")
    `NPRS_ASSERT_NEXT(a_zero_len_idle, accept && phase_reg == PH_IDLE && action == ACT_START && read_length == '0, phase_reg == PH_IDLE, "zero-length read left idle")

endmodule

// ----- src/nprs_back.sv -----
// Back end: plays each queued job out as bus results through an output register.
`include "nand_page_read_sequencer_defines.svh"

module nprs_back #(
    parameter int PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  nprs_pkg::job_t  q_job,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      m_op,
    output logic [7:0]      m_byte,
    output logic [31:0]     m_offset,
    output logic            m_last
);
    import nprs_pkg::*;

    localparam int          PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [31:0] PAGE_MASK  = 32'(PAGE_BYTES - 1);

    logic [2:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    op_t         op_reg, op_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] off_reg, off_next;
    logic        last_reg, last_next;

    logic        load, is_start, has_rel, has_seq, step_last;
    logic [2:0]  last_step;
    logic [31:0] col, page;

    assign load      = !q_empty && (!valid_reg || m_tready);
    assign is_start  = (q_job.kind == JOB_START_SEQ) || (q_job.kind == JOB_START_REL);
    assign has_rel   = (q_job.kind == JOB_START_REL) || (q_job.kind == JOB_DATA_REL);
    assign has_seq   = (q_job.kind == JOB_START_SEQ) || (q_job.kind == JOB_DATA_SEQ);
    assign last_step = has_seq ? STEP_SEQ_LAST : (has_rel ? STEP_REL_LAST : STEP_FIRST);
    assign step_last = (step_reg == last_step);
    assign col       = q_job.addr & PAGE_MASK;
    assign page      = q_job.addr >> PAGE_SHIFT;
    assign q_pop     = load && step_last;

    always_comb begin
        op_next   = OP_CMD;
        byte_next = '0;
        off_next  = '0;
        if (step_reg == STEP_FIRST) begin
            op_next   = is_start ? OP_SELECT : OP_DATA;
            byte_next = is_start ? 8'h00 : q_job.data;
            off_next  = is_start ? 32'd0 : q_job.offset;
        end else if (has_rel) begin
            op_next = OP_RELEASE;
        end else begin
            case (step_reg) inside
                STEP_COL_LO, STEP_COL_HI, STEP_PAGE_0, STEP_PAGE_1, STEP_PAGE_2:
                    op_next = OP_ADDR;
                default: op_next = OP_CMD;
            endcase
            case (step_reg)
                STEP_CMD_READ: byte_next = CMD_READ;
                STEP_COL_LO:   byte_next = col[7:0];
                STEP_COL_HI:   byte_next = col[15:8];
                STEP_PAGE_0:   byte_next = page[7:0];
                STEP_PAGE_1:   byte_next = page[15:8];
                STEP_PAGE_2:   byte_next = page[23:16];
                default:       byte_next = CMD_CONFIRM;
            endcase
        end
        last_next = step_last;
    end

    always_comb begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = step_last ? STEP_FIRST : step_reg + 3'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= STEP_FIRST;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            op_reg   <= op_next;
            byte_reg <= byte_next;
            off_reg  <= off_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_op     = op_reg;
    assign m_byte   = byte_reg;
    assign m_offset = off_reg;
    assign m_last   = last_reg;

    `NPRS_ASSERT_NOW(a_step_has_job, step_reg != STEP_FIRST, !q_empty, "mid-job step with empty queue")
    `NPRS_ASSERT_NOW(a_release_last, valid_reg && op_reg == OP_RELEASE, last_reg, "release not last of run")
    `NPRS_ASSERT_NEXT(a_pop_rewinds, q_pop, step_reg == STEP_FIRST, "step counter not rewound after job")

endmodule

// ----- src/nand_page_read_sequencer.sv -----
// Top level of the large-page NAND read sequencer.
// A start transaction selects the chip and plays out command 0x00, two column and three page
// address bytes and confirm 0x30 (a zero length gives select and release only); after a ready
// sample with the flag set, each flash data byte comes out with its destination offset, the
// read sequence is replayed at every page crossing and the chip is released after the last byte.
// Input transactions are taken one per cycle while the four-entry job queue between the front
// and back end has room, so data bytes stream at one per cycle. The back end emits one result
// per cycle while m_tready is high: a start gives 2 or 8 results, a page crossing 8, a data
// byte 1; the queue absorbs those bursts. Results pass the job queue, then the output register.
// PAGE_BYTES must be a power of two.
module nand_page_read_sequencer #(
    parameter int PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // start_address, read_length, ready_flag, flash_byte, zero pad
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bus_byte, dest_offset
    output logic [2:0]  m_tuser,   // op_kind
    output logic        m_tlast    // last_of_run
);
    import nprs_pkg::*;

    job_t        wr_job, rd_job;
    logic        q_push, q_pop, q_full, q_empty;
    logic [7:0]  bus_byte;
    logic [31:0] dest_offset;

    nprs_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .action        (s_tuser),
        .start_address (s_tdata[31:0]),
        .read_length   (s_tdata[63:32]),
        .ready_flag    (s_tdata[64]),
        .flash_byte    (s_tdata[72:65]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (wr_job)
    );

    nprs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data (wr_job),
        .rd_en   (q_pop),
        .rd_data (rd_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    nprs_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (rd_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_op     (m_tuser),
        .m_byte   (bus_byte),
        .m_offset (dest_offset),
        .m_last   (m_tlast)
    );

    assign m_tdata = {dest_offset, bus_byte};

endmodule
